>>> rtl/pgs_pkg.sv
// package for the pronunciation goodness scorer
// holds item structs, controller/datapath types, constants and helper functions
// no dependencies
`timescale 1ns / 1ps

package pgs_pkg;

    localparam int MAX_PHONES_DEF  = 64;
    localparam int LENGTH_BITS_DEF = 16;
    localparam int PHONE_BITS      = 6;

    localparam logic [15:0]        LN2_Q16    = 16'd45426;
    localparam logic signed [23:0] FRAME_MAX  = 24'sh7FFFFF;
    localparam logic signed [23:0] FRAME_MIN  = -24'sh800000;
    localparam logic signed [31:0] SKIP_VALUE = -32'sd655360;
    localparam logic signed [31:0] LOG_FLOOR  = -32'sd726816;
    localparam logic [16:0]        ONE_Q16    = 17'd65536;

    localparam logic [7:0] CFG_LOG_MODE    = 8'd0;
    localparam logic [7:0] CFG_PHONE_COUNT = 8'd1;
    localparam logic [7:0] CFG_SKIP_MASK   = 8'd2;

    localparam logic FUNC_SENONE    = 1'b0;
    localparam logic FUNC_FRAME_END = 1'b1;

    typedef struct packed {
        logic                    func;
        logic signed [23:0]      value;
        logic [63:0]             phone_mask;
        logic [PHONE_BITS-1:0]   frame_phone;
        logic [PHONE_BITS-1:0]   next_phone;
        logic                    last_frame;
    } t_in_item;

    typedef struct packed {
        logic [PHONE_BITS-1:0]   segment_phone;
        logic [PHONE_BITS-1:0]   phone_index;
        logic signed [31:0]      mean_log_post;
        logic signed [31:0]      log_post_ratio;
        logic signed [31:0]      gop_score;
        logic                    last_of_run;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE, S_EXP_DIV, S_EXP_KR, S_EXP_MUL, S_EXP_SCL, S_EXP_FIN,
        S_ACC_RD, S_ACC_WR, S_FW_RD, S_FW_LOAD, S_LOG_NORM, S_LOG_DIV,
        S_LOG_Z2, S_SER_MUL, S_SER_ADD, S_LOG_FIN, S_FW_ADD, S_AVG_DIV,
        S_AVG_WR, S_FW_DONE, S_EM_RD, S_EM_WAIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_EXP_DIV, OP_EXP_KR, OP_EXP_MUL, OP_EXP_SCL,
        OP_EXP_FIN, OP_ACC_RD, OP_ACC_WR, OP_FW_RD, OP_FW_LOAD, OP_LOG_NORM,
        OP_LOG_DIV, OP_LOG_Z2, OP_SER_MUL, OP_SER_ADD, OP_LOG_FIN, OP_FW_ADD,
        OP_AVG_DIV, OP_AVG_WR, OP_FW_DONE, OP_EM_RD, OP_EM_WAIT
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [PHONE_BITS-1:0] k;
        logic [5:0]            step;
        logic                  first;
        logic                  last;
    } t_cmd;

    typedef struct packed {
        logic       in_frame_end;
        logic       log_mode;
        logic       seg_end;
        logic       emit_ok;
        logic       take_log;
        logic       u_norm;
        logic       out_free;
        logic [6:0] cnt;
    } t_status;

    function automatic logic [31:0] sat32(input logic signed [32:0] v);
        logic [31:0] r;
        if (v > 33'sh07FFFFFFF) begin
            r = 32'h7FFFFFFF;
        end else if (v < -33'sh080000000) begin
            r = 32'h80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [23:0] sat24(input logic signed [25:0] v);
        logic [23:0] r;
        if (v > 26'(FRAME_MAX)) begin
            r = FRAME_MAX;
        end else if (v < 26'(FRAME_MIN)) begin
            r = FRAME_MIN;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // truncating divide of a 17-bit value by 1..9 through a reciprocal
    function automatic logic [16:0] div_small(input logic [16:0] x, input logic [3:0] n);
        logic [21:0] m;
        logic [38:0] prod;
        unique case (n)
            4'd2:    m = 22'd1048576;
            4'd3:    m = 22'd699051;
            4'd4:    m = 22'd524288;
            4'd5:    m = 22'd419431;
            4'd6:    m = 22'd349526;
            4'd7:    m = 22'd299594;
            4'd8:    m = 22'd262144;
            4'd9:    m = 22'd233017;
            default: m = 22'd2097152;
        endcase
        prod = 39'(x) * 39'(m);
        return prod[37:21];
    endfunction

endpackage

>>> rtl/pgs_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pgs_ctrl.sv
// controller state machine: sequences senone accumulation, frame walk and emission
// depends on pgs_pkg
`timescale 1ns / 1ps

module pgs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pgs_pkg::t_status i_status,
    output pgs_pkg::t_cmd    o_cmd
);

    pgs_pkg::t_state r_state, n_state;
    logic [pgs_pkg::PHONE_BITS-1:0] r_k, n_k;
    logic [5:0] r_step, n_step;
    logic       w_last;
    logic       w_accept;

    assign w_last   = ({1'b0, r_k} == (i_status.cnt - 7'd1));
    assign w_accept = (r_state == pgs_pkg::S_IDLE) && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pgs_pkg::S_IDLE;
            r_k     <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_step  <= n_step;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_step  = r_step;
        unique case (r_state)
            pgs_pkg::S_IDLE: begin
                n_k    = '0;
                n_step = '0;
                if (w_accept) begin
                    if (i_status.in_frame_end) begin
                        n_state = pgs_pkg::S_FW_RD;
                    end else if (i_status.log_mode) begin
                        n_state = pgs_pkg::S_EXP_DIV;
                    end else begin
                        n_state = pgs_pkg::S_ACC_RD;
                    end
                end
            end
            pgs_pkg::S_EXP_DIV: begin
                if (r_step == 6'd7) begin
                    n_state = pgs_pkg::S_EXP_KR;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 6'd1;
                end
            end
            pgs_pkg::S_EXP_KR:  n_state = pgs_pkg::S_EXP_MUL;
            pgs_pkg::S_EXP_MUL: n_state = pgs_pkg::S_EXP_SCL;
            pgs_pkg::S_EXP_SCL: begin
                if (r_step == 6'd7) begin
                    n_state = pgs_pkg::S_EXP_FIN;
                    n_step  = '0;
                end else begin
                    n_state = pgs_pkg::S_EXP_MUL;
                    n_step  = r_step + 6'd1;
                end
            end
            pgs_pkg::S_EXP_FIN: n_state = pgs_pkg::S_ACC_RD;
            pgs_pkg::S_ACC_RD:  n_state = pgs_pkg::S_ACC_WR;
            pgs_pkg::S_ACC_WR: begin
                if (w_last) begin
                    n_state = pgs_pkg::S_IDLE;
                    n_k     = '0;
                end else begin
                    n_state = pgs_pkg::S_ACC_RD;
                    n_k     = r_k + 1'b1;
                end
            end
            pgs_pkg::S_FW_RD:   n_state = pgs_pkg::S_FW_LOAD;
            pgs_pkg::S_FW_LOAD: begin
                n_state = i_status.take_log ? pgs_pkg::S_LOG_NORM : pgs_pkg::S_FW_ADD;
            end
            pgs_pkg::S_LOG_NORM: begin
                if (i_status.u_norm) begin
                    n_state = pgs_pkg::S_LOG_DIV;
                    n_step  = '0;
                end
            end
            pgs_pkg::S_LOG_DIV: begin
                if (r_step == 6'd15) begin
                    n_state = pgs_pkg::S_LOG_Z2;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 6'd1;
                end
            end
            pgs_pkg::S_LOG_Z2:  n_state = pgs_pkg::S_SER_MUL;
            pgs_pkg::S_SER_MUL: n_state = pgs_pkg::S_SER_ADD;
            pgs_pkg::S_SER_ADD: begin
                if (r_step == 6'd3) begin
                    n_state = pgs_pkg::S_LOG_FIN;
                    n_step  = '0;
                end else begin
                    n_state = pgs_pkg::S_SER_MUL;
                    n_step  = r_step + 6'd1;
                end
            end
            pgs_pkg::S_LOG_FIN: n_state = pgs_pkg::S_FW_ADD;
            pgs_pkg::S_FW_ADD: begin
                n_step = '0;
                if (i_status.emit_ok) begin
                    n_state = pgs_pkg::S_AVG_DIV;
                end else if (w_last) begin
                    n_state = pgs_pkg::S_FW_DONE;
                end else begin
                    n_state = pgs_pkg::S_FW_RD;
                    n_k     = r_k + 1'b1;
                end
            end
            pgs_pkg::S_AVG_DIV: begin
                if (r_step == 6'd31) begin
                    n_state = pgs_pkg::S_AVG_WR;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 6'd1;
                end
            end
            pgs_pkg::S_AVG_WR: begin
                if (w_last) begin
                    n_state = pgs_pkg::S_FW_DONE;
                end else begin
                    n_state = pgs_pkg::S_FW_RD;
                    n_k     = r_k + 1'b1;
                end
            end
            pgs_pkg::S_FW_DONE: begin
                n_k     = '0;
                n_state = i_status.emit_ok ? pgs_pkg::S_EM_RD : pgs_pkg::S_IDLE;
            end
            pgs_pkg::S_EM_RD: n_state = pgs_pkg::S_EM_WAIT;
            pgs_pkg::S_EM_WAIT: begin
                if (i_status.out_free) begin
                    if (w_last) begin
                        n_state = pgs_pkg::S_IDLE;
                        n_k     = '0;
                    end else begin
                        n_state = pgs_pkg::S_EM_RD;
                        n_k     = r_k + 1'b1;
                    end
                end
            end
            default: n_state = pgs_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.k     = r_k;
        o_cmd.step  = r_step;
        o_cmd.first = (r_k == '0);
        o_cmd.last  = w_last;
        o_in_ready  = (r_state == pgs_pkg::S_IDLE);
        unique case (r_state)
            pgs_pkg::S_IDLE:     o_cmd.op = w_accept ? pgs_pkg::OP_LATCH : pgs_pkg::OP_NONE;
            pgs_pkg::S_EXP_DIV:  o_cmd.op = pgs_pkg::OP_EXP_DIV;
            pgs_pkg::S_EXP_KR:   o_cmd.op = pgs_pkg::OP_EXP_KR;
            pgs_pkg::S_EXP_MUL:  o_cmd.op = pgs_pkg::OP_EXP_MUL;
            pgs_pkg::S_EXP_SCL:  o_cmd.op = pgs_pkg::OP_EXP_SCL;
            pgs_pkg::S_EXP_FIN:  o_cmd.op = pgs_pkg::OP_EXP_FIN;
            pgs_pkg::S_ACC_RD:   o_cmd.op = pgs_pkg::OP_ACC_RD;
            pgs_pkg::S_ACC_WR:   o_cmd.op = pgs_pkg::OP_ACC_WR;
            pgs_pkg::S_FW_RD:    o_cmd.op = pgs_pkg::OP_FW_RD;
            pgs_pkg::S_FW_LOAD:  o_cmd.op = pgs_pkg::OP_FW_LOAD;
            pgs_pkg::S_LOG_NORM: o_cmd.op = pgs_pkg::OP_LOG_NORM;
            pgs_pkg::S_LOG_DIV:  o_cmd.op = pgs_pkg::OP_LOG_DIV;
            pgs_pkg::S_LOG_Z2:   o_cmd.op = pgs_pkg::OP_LOG_Z2;
            pgs_pkg::S_SER_MUL:  o_cmd.op = pgs_pkg::OP_SER_MUL;
            pgs_pkg::S_SER_ADD:  o_cmd.op = pgs_pkg::OP_SER_ADD;
            pgs_pkg::S_LOG_FIN:  o_cmd.op = pgs_pkg::OP_LOG_FIN;
            pgs_pkg::S_FW_ADD:   o_cmd.op = pgs_pkg::OP_FW_ADD;
            pgs_pkg::S_AVG_DIV:  o_cmd.op = pgs_pkg::OP_AVG_DIV;
            pgs_pkg::S_AVG_WR:   o_cmd.op = pgs_pkg::OP_AVG_WR;
            pgs_pkg::S_FW_DONE:  o_cmd.op = pgs_pkg::OP_FW_DONE;
            pgs_pkg::S_EM_RD:    o_cmd.op = pgs_pkg::OP_EM_RD;
            pgs_pkg::S_EM_WAIT:  o_cmd.op = pgs_pkg::OP_EM_WAIT;
            default:             o_cmd.op = pgs_pkg::OP_NONE;
        endcase
    end

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_k} < i_status.cnt))
        else $error("phone counter beyond phone count");

    a_idle_k_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pgs_pkg::S_IDLE) |-> (r_k == '0))
        else $error("phone counter not cleared in idle");

endmodule

>>> rtl/pgs_dp.sv
// datapath: config registers, exp and log units, dividers, phone memories, output register
// depends on pgs_pkg and pgs_ram
`timescale 1ns / 1ps

module pgs_dp #(
    parameter int MAX_PHONES  = pgs_pkg::MAX_PHONES_DEF,
    parameter int LENGTH_BITS = pgs_pkg::LENGTH_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pgs_pkg::t_in_item i_in_data,
    input  logic              i_cfg_valid,
    input  logic [7:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pgs_pkg::t_out_item o_out_data,
    input  pgs_pkg::t_cmd     i_cmd,
    output pgs_pkg::t_status  o_status
);

    localparam int IW = $clog2(MAX_PHONES);

    // config
    logic        r_log_mode;
    logic [6:0]  r_phone_count;
    logic [63:0] r_skip;
    logic [6:0]  w_cnt;

    // item and segment state
    pgs_pkg::t_in_item          r_item;
    logic [LENGTH_BITS-1:0]     r_len;
    logic [MAX_PHONES-1:0]      r_fvld;
    logic [MAX_PHONES-1:0]      r_svld;
    logic                       r_rd_fv;
    logic                       r_rd_sv;

    // exp unit
    logic [23:0]        r_erem;
    logic [7:0]         r_eq;
    logic               r_eneg;
    logic signed [8:0]  r_ek;
    logic [15:0]        r_er;
    logic [16:0]        r_term;
    logic [32:0]        r_eprod;
    logic [17:0]        r_esum;
    logic signed [24:0] r_p;

    // log unit
    logic [22:0]        r_u;
    logic [4:0]         r_sh;
    logic [17:0]        r_lr;
    logic [15:0]        r_z;
    logic [15:0]        r_z2;
    logic [15:0]        r_t;
    logic [31:0]        r_tp;
    logic [16:0]        r_acc;
    logic signed [31:0] r_fv;
    logic signed [31:0] r_seg;

    // average divider and scores
    logic [LENGTH_BITS-1:0] r_dr;
    logic [31:0]            r_dq;
    logic                   r_dneg;
    logic signed [31:0]     r_max;
    logic signed [31:0]     r_own;

    logic                   r_out_valid;
    pgs_pkg::t_out_item     r_out;

    // memory ports
    logic [IW-1:0] w_addr;
    logic [23:0]   w_frame_q, w_frame_wd;
    logic [31:0]   w_seg_q, w_seg_wd, w_avg_q, w_avg_wd;
    logic          w_frame_we, w_seg_we, w_avg_we;

    logic signed [23:0] w_fs;
    logic signed [31:0] w_sq;
    logic [17:0]        w_den;
    logic [18:0]        w_lr2;
    logic [LENGTH_BITS:0] w_dr2;
    logic [23:0]        w_ecmp;
    logic signed [5:0]  w_pe;
    logic signed [31:0] w_avg;
    logic               w_out_free;
    logic               w_seg_end;
    logic               w_emit_ok;
    logic [15:0]        w_t;
    logic [24:0]        w_e;
    logic [8:0]         w_nk;
    logic [31:0]        w_segn;

    assign w_addr = i_cmd.k[IW-1:0];

    pgs_ram #(.WIDTH(24), .DEPTH(MAX_PHONES)) u_frame_ram (
        .i_clk(i_clk), .i_we(w_frame_we), .i_waddr(w_addr), .i_wdata(w_frame_wd),
        .i_raddr(w_addr), .o_rdata(w_frame_q)
    );

    pgs_ram #(.WIDTH(32), .DEPTH(MAX_PHONES)) u_seg_ram (
        .i_clk(i_clk), .i_we(w_seg_we), .i_waddr(w_addr), .i_wdata(w_seg_wd),
        .i_raddr(w_addr), .o_rdata(w_seg_q)
    );

    pgs_ram #(.WIDTH(32), .DEPTH(MAX_PHONES)) u_avg_ram (
        .i_clk(i_clk), .i_we(w_avg_we), .i_waddr(w_addr), .i_wdata(w_avg_wd),
        .i_raddr(w_addr), .o_rdata(w_avg_q)
    );

    always_comb begin
        if (r_phone_count == 7'd0) begin
            w_cnt = 7'd1;
        end else if (r_phone_count > 7'(MAX_PHONES)) begin
            w_cnt = 7'(MAX_PHONES);
        end else begin
            w_cnt = r_phone_count;
        end
    end

    assign w_fs       = r_rd_fv ? $signed(w_frame_q) : 24'sd0;
    assign w_sq       = r_rd_sv ? $signed(w_seg_q) : 32'sd0;
    assign w_den      = {1'b0, r_u[22:6]} + 18'(pgs_pkg::ONE_Q16);
    assign w_lr2      = {r_lr, 1'b0};
    assign w_dr2      = {r_dr, r_dq[31]};
    assign w_ecmp     = 24'(pgs_pkg::LN2_Q16) << (3'd7 - i_cmd.step[2:0]);
    assign w_pe       = 6'sd6 - $signed({1'b0, r_sh});
    assign w_avg      = $signed(w_avg_q);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_seg_end  = (r_item.next_phone != r_item.frame_phone) || r_item.last_frame;
    assign w_emit_ok  = w_seg_end && ({1'b0, r_item.frame_phone} < w_cnt)
                        && !r_skip[r_item.frame_phone];
    assign w_t        = r_tp[31:16];
    assign w_nk       = -r_ek;
    assign w_e        = 25'(r_esum) << r_ek[2:0];
    assign w_segn     = pgs_pkg::sat32(33'(r_seg) + 33'(r_fv));

    assign w_frame_we = (i_cmd.op == pgs_pkg::OP_ACC_WR) && r_item.phone_mask[i_cmd.k];
    assign w_frame_wd = pgs_pkg::sat24(26'(w_fs) + 26'(r_p));
    assign w_seg_we   = (i_cmd.op == pgs_pkg::OP_FW_ADD);
    assign w_seg_wd   = w_segn;
    assign w_avg_we   = (i_cmd.op == pgs_pkg::OP_AVG_WR);
    assign w_avg_wd   = r_dneg ? (32'd0 - r_dq) : r_dq;

    always_comb begin
        o_status.in_frame_end = (i_in_data.func == pgs_pkg::FUNC_FRAME_END);
        o_status.log_mode     = r_log_mode;
        o_status.seg_end      = w_seg_end;
        o_status.emit_ok      = w_emit_ok;
        o_status.take_log     = !r_skip[i_cmd.k] && (w_fs > 24'sd0);
        o_status.u_norm       = r_u[22];
        o_status.out_free     = w_out_free;
        o_status.cnt          = w_cnt;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_mode    <= 1'b1;
            r_phone_count <= 7'd64;
            r_skip        <= 64'd1;
            r_len         <= '0;
            r_fvld        <= '0;
            r_svld        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    pgs_pkg::CFG_LOG_MODE:    r_log_mode    <= i_cfg_data[0];
                    pgs_pkg::CFG_PHONE_COUNT: r_phone_count <= i_cfg_data[6:0];
                    pgs_pkg::CFG_SKIP_MASK:   r_skip        <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == pgs_pkg::OP_LATCH
                && i_in_data.func == pgs_pkg::FUNC_FRAME_END && r_len != '1) begin
                r_len <= r_len + 1'b1;
            end
            if (w_frame_we) begin
                r_fvld[w_addr] <= 1'b1;
            end
            if (w_seg_we) begin
                r_svld[w_addr] <= 1'b1;
            end
            if (i_cmd.op == pgs_pkg::OP_FW_DONE) begin
                r_fvld <= '0;
                if (w_seg_end) begin
                    r_svld <= '0;
                    r_len  <= '0;
                end
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.op == pgs_pkg::OP_EM_WAIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // arithmetic
    always_ff @(posedge i_clk) begin
        r_rd_fv <= r_fvld[w_addr];
        r_rd_sv <= r_svld[w_addr];
        unique case (i_cmd.op)
            pgs_pkg::OP_LATCH: begin
                r_item <= i_in_data;
                r_p    <= 25'(i_in_data.value);
                r_eneg <= i_in_data.value[23];
                r_erem <= i_in_data.value[23] ? (24'd0 - i_in_data.value) : i_in_data.value;
                r_eq   <= '0;
            end
            pgs_pkg::OP_EXP_DIV: begin
                if (r_erem >= w_ecmp) begin
                    r_erem <= r_erem - w_ecmp;
                    r_eq   <= {r_eq[6:0], 1'b1};
                end else begin
                    r_eq   <= {r_eq[6:0], 1'b0};
                end
            end
            pgs_pkg::OP_EXP_KR: begin
                if (r_eneg && r_erem != '0) begin
                    r_ek <= -$signed({1'b0, r_eq}) - 9'sd1;
                    r_er <= pgs_pkg::LN2_Q16 - r_erem[15:0];
                end else if (r_eneg) begin
                    r_ek <= -$signed({1'b0, r_eq});
                    r_er <= '0;
                end else begin
                    r_ek <= $signed({1'b0, r_eq});
                    r_er <= r_erem[15:0];
                end
                r_term <= pgs_pkg::ONE_Q16;
                r_esum <= 18'(pgs_pkg::ONE_Q16);
            end
            pgs_pkg::OP_EXP_MUL: begin
                r_eprod <= 33'(r_term) * 33'(r_er);
            end
            pgs_pkg::OP_EXP_SCL: begin
                r_term <= pgs_pkg::div_small(r_eprod[32:16], 4'(i_cmd.step) + 4'd1);
                r_esum <= r_esum
                    + 18'(pgs_pkg::div_small(r_eprod[32:16], 4'(i_cmd.step) + 4'd1));
            end
            pgs_pkg::OP_EXP_FIN: begin
                if (r_ek >= 9'sd8) begin
                    r_p <= 25'(pgs_pkg::FRAME_MAX);
                end else if (!r_ek[8]) begin
                    r_p <= (w_e > 25'(pgs_pkg::FRAME_MAX)) ? 25'(pgs_pkg::FRAME_MAX) : w_e;
                end else if (w_nk >= 9'd32) begin
                    r_p <= '0;
                end else begin
                    r_p <= 25'(r_esum >> w_nk[4:0]);
                end
            end
            pgs_pkg::OP_FW_LOAD: begin
                r_seg <= w_sq;
                r_u   <= w_fs[22:0];
                r_sh  <= '0;
                r_fv  <= r_skip[i_cmd.k] ? pgs_pkg::SKIP_VALUE : pgs_pkg::LOG_FLOOR;
            end
            pgs_pkg::OP_LOG_NORM: begin
                if (r_u[22]) begin
                    r_lr <= {2'b0, r_u[21:6]};
                    r_z  <= '0;
                end else if (r_u[22:15] == '0) begin
                    r_u  <= r_u << 8;
                    r_sh <= r_sh + 5'd8;
                end else if (r_u[22:19] == '0) begin
                    r_u  <= r_u << 4;
                    r_sh <= r_sh + 5'd4;
                end else begin
                    r_u  <= r_u << 1;
                    r_sh <= r_sh + 5'd1;
                end
            end
            pgs_pkg::OP_LOG_DIV: begin
                if (w_lr2 >= 19'(w_den)) begin
                    r_lr <= 18'(w_lr2 - 19'(w_den));
                    r_z  <= {r_z[14:0], 1'b1};
                end else begin
                    r_lr <= w_lr2[17:0];
                    r_z  <= {r_z[14:0], 1'b0};
                end
            end
            pgs_pkg::OP_LOG_Z2: begin
                r_tp  <= 32'(r_z) * 32'(r_z);
                r_t   <= r_z;
                r_acc <= 17'(r_z);
            end
            pgs_pkg::OP_SER_MUL: begin
                if (i_cmd.step == '0) begin
                    r_z2 <= r_tp[31:16];
                    r_tp <= 32'(r_t) * 32'(r_tp[31:16]);
                end else begin
                    r_tp <= 32'(r_t) * 32'(r_z2);
                end
            end
            pgs_pkg::OP_SER_ADD: begin
                r_t   <= w_t;
                r_acc <= r_acc
                    + pgs_pkg::div_small(17'(w_t), 4'd3 + {i_cmd.step[2:0], 1'b0});
            end
            pgs_pkg::OP_LOG_FIN: begin
                r_fv <= 32'(w_pe) * 32'sd45426 + $signed({14'd0, r_acc, 1'b0});
            end
            pgs_pkg::OP_FW_ADD: begin
                r_dneg <= w_segn[31];
                r_dq   <= w_segn[31] ? (32'd0 - w_segn) : w_segn;
                r_dr   <= '0;
            end
            pgs_pkg::OP_AVG_DIV: begin
                if (w_dr2 >= {1'b0, r_len}) begin
                    r_dr <= LENGTH_BITS'(w_dr2 - {1'b0, r_len});
                    r_dq <= {r_dq[30:0], 1'b1};
                end else begin
                    r_dr <= w_dr2[LENGTH_BITS-1:0];
                    r_dq <= {r_dq[30:0], 1'b0};
                end
            end
            pgs_pkg::OP_AVG_WR: begin
                if (i_cmd.first || $signed(w_avg_wd) > r_max) begin
                    r_max <= $signed(w_avg_wd);
                end
                if (i_cmd.k == r_item.frame_phone) begin
                    r_own <= $signed(w_avg_wd);
                end
            end
            pgs_pkg::OP_EM_WAIT: begin
                if (w_out_free) begin
                    r_out.segment_phone  <= r_item.frame_phone;
                    r_out.phone_index    <= i_cmd.k;
                    r_out.mean_log_post  <= w_avg;
                    r_out.log_post_ratio <= pgs_pkg::sat32(33'(r_own) - 33'(w_avg));
                    r_out.gop_score      <= pgs_pkg::sat32(33'(r_own) - 33'(r_max));
                    r_out.last_of_run    <= i_cmd.last;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_log_normalized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == pgs_pkg::OP_LOG_DIV) |-> (r_u[22] && (r_lr < w_den)))
        else $error("log divider entered unnormalized or with remainder too large");

    a_avg_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == pgs_pkg::OP_AVG_DIV) |-> (r_dr < r_len))
        else $error("average divider remainder not below segment length");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.op == pgs_pkg::OP_EM_WAIT))
        else $error("result loaded outside emission");

    a_emit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == pgs_pkg::OP_AVG_DIV) |-> (r_len != '0))
        else $error("averaging with zero length");

endmodule

>>> rtl/pronunciation_goodness_scorer_core.sv
// top level of the pronunciation goodness scorer: controller plus datapath
// depends on pgs_pkg, pgs_ctrl, pgs_dp, pgs_ram
//
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_ready    i_in_data   (t_in_item)
// out      output     o_out_valid / i_out_ready  o_out_data  (t_out_item)
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// senone transaction: an accumulate read and write per phone, preceded by the exp unit in log mode
// frame end transaction: per phone a read and a load, then the log unit when it runs,
//   the serial divider at a segment end that reports, then a read and a wait per result
// frame sums and segment sums clear through per-phone valid flags, no clearing pass
// reset is synchronous, active low; a stalled result register holds the walk, config is always ready
`timescale 1ns / 1ps

module pronunciation_goodness_scorer_core #(
    parameter int MAX_PHONES  = pgs_pkg::MAX_PHONES_DEF,
    parameter int LENGTH_BITS = pgs_pkg::LENGTH_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pgs_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pgs_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    pgs_pkg::t_cmd    w_cmd;
    pgs_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    pgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pgs_dp #(
        .MAX_PHONES (MAX_PHONES),
        .LENGTH_BITS(LENGTH_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule
